// ----- hw/rtl/sfsg_pkg.sv -----
// package: shared widths, register indexes, reset values and control structs
`default_nettype none
package sfsg_pkg;

  // fixed field and register widths
  localparam int unsigned CLK_W      = 27;
  localparam int unsigned FREQ_CFG_W = 16;
  localparam int unsigned TPS_W      = 8;
  localparam int unsigned PFREQ_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 27;

  // parameter defaults
  localparam int unsigned DEF_FREQ_BITS   = 16;
  localparam int unsigned DEF_PERIOD_BITS = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FREQ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_FREQ   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOGGLES     = 2'd3;

  // register reset values
  localparam logic [CLK_W-1:0]      RST_CLOCK_RATE = 27'd3685000;
  localparam logic [FREQ_CFG_W-1:0] RST_FIRST_FREQ = 16'd2500;
  localparam logic [FREQ_CFG_W-1:0] RST_LAST_FREQ  = 16'd3100;
  localparam logic [TPS_W-1:0]      RST_TOGGLES    = 8'd5;

  // controller to datapath
  typedef struct packed {
    logic tick;
  } sfsg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_req;
    logic div_done;
  } sfsg_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sfsg_if.sv -----
// interfaces: tick request channel and result channel
`default_nettype none
interface sfsg_in_if;
  logic valid;
  logic ready;
  logic start_request;

  modport source (output valid, output start_request, input ready);
  modport sink (input valid, input start_request, output ready);
endinterface

interface sfsg_out_if;
  logic        valid;
  logic        ready;
  logic        drive_level;
  logic        sweep_done;
  logic        sweeping;
  logic [15:0] present_frequency;

  modport source (output valid, output drive_level, output sweep_done,
                  output sweeping, output present_frequency, input ready);
  modport sink (input valid, input drive_level, input sweep_done,
                input sweeping, input present_frequency, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/stepped_frequency_sweep_generator.sv -----
// top level: stepped frequency sweep square-wave generator
//
//  channel  dir  word fields
//  req_i    in   start_request
//  res_o    out  drive_level, sweep_done, sweeping, present_frequency
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// each accepted word is one timer tick, yielding one result word in the next cycle
// a word that arms the sweep or steps the frequency starts the 27-step restoring
// divider; the next word is taken after the divider is done, other words back to back
// the result register frees as its word is taken, so a new word enters that cycle
// reset is asynchronous active low; output parks high at the start frequency
`default_nettype none
module stepped_frequency_sweep_generator #(
  parameter int unsigned FREQ_BITS   = sfsg_pkg::DEF_FREQ_BITS,
  parameter int unsigned PERIOD_BITS = sfsg_pkg::DEF_PERIOD_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [sfsg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sfsg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sfsg_in_if.sink                              req_i,
  sfsg_out_if.source                           res_o
);
  import sfsg_pkg::*;

  sfsg_cmd_t  cmd;
  sfsg_stat_t stat;

  sfsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .cmd_o       (cmd)
  );

  sfsg_datapath #(
    .FREQ_BITS   (FREQ_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .start_request_i     (req_i.start_request),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .drive_level_o       (res_o.drive_level),
    .sweep_done_o        (res_o.sweep_done),
    .sweeping_o          (res_o.sweeping),
    .present_frequency_o (res_o.present_frequency)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/sfsg_div.sv -----
// restoring divider: clock rate over frequency, one quotient bit per cycle, halved or quartered at the output
`default_nettype none
module sfsg_div #(
  parameter int unsigned FREQ_BITS   = sfsg_pkg::DEF_FREQ_BITS,
  parameter int unsigned PERIOD_BITS = sfsg_pkg::DEF_PERIOD_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [sfsg_pkg::CLK_W-1:0]    dividend_i,
  input  wire logic [FREQ_BITS-1:0]          divisor_i,
  input  wire logic                          shift_two_i,
  output logic                               done_o,
  output logic [PERIOD_BITS-1:0]             period_o
);
  import sfsg_pkg::*;

  localparam int unsigned CNT_W = $clog2(CLK_W);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [CLK_W-1:0]     num_q, num_d;
  logic [FREQ_BITS-1:0] rem_q, rem_d;
  logic [FREQ_BITS-1:0] den_q;
  logic                 sh2_q;
  logic [FREQ_BITS:0]   trial;
  logic [FREQ_BITS:0]   diff;
  logic                 qbit;

  always_comb begin
    trial = {rem_q, num_q[CLK_W-1]};
    diff  = trial - {1'b0, den_q};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = qbit ? diff[FREQ_BITS-1:0] : trial[FREQ_BITS-1:0];
    num_d = {num_q[CLK_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(CLK_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      // a zero frequency divides as one
      den_q <= (divisor_i == '0) ? FREQ_BITS'(1) : divisor_i;
      sh2_q <= shift_two_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o   = done_q;
  assign period_o = sh2_q ? PERIOD_BITS'(num_q >> 2) : PERIOD_BITS'(num_q >> 1);

endmodule
`default_nettype wire

// ----- hw/rtl/sfsg_datapath.sv -----
// datapath: config registers, sweep timer, toggle counter, frequency and period
`default_nettype none
module sfsg_datapath #(
  parameter int unsigned FREQ_BITS   = sfsg_pkg::DEF_FREQ_BITS,
  parameter int unsigned PERIOD_BITS = sfsg_pkg::DEF_PERIOD_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [sfsg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sfsg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            start_request_i,
  input  wire sfsg_pkg::sfsg_cmd_t             cmd_i,
  output sfsg_pkg::sfsg_stat_t                 stat_o,
  output logic                                 drive_level_o,
  output logic                                 sweep_done_o,
  output logic                                 sweeping_o,
  output logic [sfsg_pkg::PFREQ_W-1:0]         present_frequency_o
);
  import sfsg_pkg::*;

  logic [CLK_W-1:0]       clk_rate_q;
  logic [FREQ_CFG_W-1:0]  first_q;
  logic [FREQ_CFG_W-1:0]  last_q;
  logic [TPS_W-1:0]       tps_q;

  logic [PERIOD_BITS-1:0] tick_q;
  logic [PERIOD_BITS-1:0] half_q;
  logic [FREQ_BITS-1:0]   freq_q, freq_d;
  logic [TPS_W-1:0]       tog_q, tog_d;
  logic                   level_q, level_d;
  logic                   run_q, run_d;
  logic                   done_q, done_d;
  logic [PERIOD_BITS-1:0] tick_d;

  logic [FREQ_BITS-1:0]   first_m;
  logic [FREQ_BITS-1:0]   last_m;
  logic [FREQ_BITS-1:0]   freq_inc;
  logic [TPS_W-1:0]       tog_inc;
  logic                   match;
  logic                   arm;
  logic                   step;
  logic                   div_done;
  logic [PERIOD_BITS-1:0] div_period;

  assign first_m  = FREQ_BITS'(first_q);
  assign last_m   = FREQ_BITS'(last_q);
  assign freq_inc = (freq_q == '1) ? freq_q : freq_q + 1'b1;
  assign tog_inc  = tog_q + 1'b1;
  assign match    = (tick_q == half_q);
  assign arm      = !run_q && start_request_i;
  assign step     = run_q && match && (tog_inc == tps_q);

  always_comb begin
    tick_d  = tick_q;
    freq_d  = freq_q;
    tog_d   = tog_q;
    level_d = level_q;
    run_d   = run_q;
    done_d  = 1'b0;
    if (!run_q) begin
      if (start_request_i) begin
        run_d   = 1'b1;
        level_d = 1'b1;
        tick_d  = '0;
        tog_d   = '0;
        freq_d  = first_m;
      end
    end else if (!match) begin
      tick_d = tick_q + 1'b1;
    end else begin
      tick_d  = '0;
      level_d = !level_q;
      tog_d   = tog_inc;
      if (tog_inc == tps_q) begin
        freq_d = freq_inc;
        tog_d  = '0;
      end else if (freq_q == last_m) begin
        // sweep end: back to the start frequency, output parked high
        freq_d  = first_m;
        tog_d   = '0;
        level_d = 1'b1;
        run_d   = 1'b0;
        done_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_rate_q <= RST_CLOCK_RATE;
      first_q    <= RST_FIRST_FREQ;
      last_q     <= RST_LAST_FREQ;
      tps_q      <= RST_TOGGLES;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CLOCK_RATE: clk_rate_q <= cfg_data_i[CLK_W-1:0];
        REG_FIRST_FREQ: first_q    <= cfg_data_i[FREQ_CFG_W-1:0];
        REG_LAST_FREQ:  last_q     <= cfg_data_i[FREQ_CFG_W-1:0];
        REG_TOGGLES:    tps_q      <= cfg_data_i[TPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      half_q  <= '0;
      freq_q  <= FREQ_BITS'(RST_FIRST_FREQ);
      tog_q   <= '0;
      level_q <= 1'b1;
      run_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (cmd_i.tick) begin
        tick_q  <= tick_d;
        freq_q  <= freq_d;
        tog_q   <= tog_d;
        level_q <= level_d;
        run_q   <= run_d;
        done_q  <= done_d;
      end
      if (div_done) begin
        half_q <= div_period;
      end
    end
  end

  sfsg_div #(
    .FREQ_BITS   (FREQ_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.tick && (arm || step)),
    .dividend_i  (clk_rate_q),
    .divisor_i   (freq_d),
    .shift_two_i (arm),
    .done_o      (div_done),
    .period_o    (div_period)
  );

  assign stat_o.div_req  = arm || step;
  assign stat_o.div_done = div_done;

  assign drive_level_o       = level_q;
  assign sweep_done_o        = done_q;
  assign sweeping_o          = run_q;
  assign present_frequency_o = PFREQ_W'(freq_q);

endmodule
`default_nettype wire

// ----- hw/rtl/sfsg_ctrl.sv -----
// controller: handshakes, result valid and wait for period division
`default_nettype none
module sfsg_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 out_ready_i,
  input  wire sfsg_pkg::sfsg_stat_t stat_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  output sfsg_pkg::sfsg_cmd_t       cmd_o
);
  import sfsg_pkg::*;

  localparam logic ST_RUN = 1'b0;
  localparam logic ST_DIV = 1'b1;

  logic state_q, state_d;
  logic oval_q, oval_d;
  logic accept;

  assign in_ready_o = (state_q == ST_RUN) && (!oval_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (accept && stat_i.div_req) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    oval_d = oval_q;
    if (accept) begin
      oval_d = 1'b1;
    end else if (out_ready_i) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

  assign out_valid_o = oval_q;
  assign cmd_o.tick  = accept;

endmodule
`default_nettype wire
